// ----- hw/rtl/stpf_pkg.sv -----
package stpf_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int FRAME_LEN    = 29;
	localparam int CRC_LEN      = 26;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [7:0]  END_MARK = 8'h0D;
	localparam logic [7:0]  HDR_PRIORITY = 8'hFF;
	localparam logic [7:0]  HDR_NORMAL   = 8'hAA;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_WEIGHT_GAS   = 3'd0;
	localparam logic [2:0] REG_WEIGHT_DUST  = 3'd1;
	localparam logic [2:0] REG_PRIORITY     = 3'd2;
	localparam logic [2:0] REG_ELEVATED     = 3'd3;
	localparam logic [2:0] REG_NODE_IDENT   = 3'd4;
	localparam logic [2:0] REG_HAZARD_KIND  = 3'd5;
	localparam logic [2:0] REG_BATT_FULL    = 3'd6;
	localparam logic [2:0] REG_BATT_EMPTY   = 3'd7;

	typedef struct packed {
		logic [11:0] gas_code;
		logic [11:0] dust_code;
		logic [11:0] battery_code;
	} sensor_in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
		logic [1:0] urgency;
	} frame_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_AQI,
		ST_DIV_DUST,
		ST_DIV_MV,
		ST_ANOM,
		ST_DIV_A1,
		ST_DIV_A2,
		ST_COMB,
		ST_BATT,
		ST_DIV_BATT,
		ST_FLOAT,
		ST_BUILD,
		ST_CRC,
		ST_SEND
	} stpf_state_t;

endpackage

// ----- hw/rtl/sensor_telemetry_packet_framer_unit.sv -----
// Channel   | Signals                   | Beat content
// ----------+---------------------------+-------------------------------------
// in        | in_valid, in_ready, in_data   | one set of gas, dust, battery codes
// out       | out_valid, out_ready, out_data| one frame byte, last flag, urgency
// cfg       | cfg_we, cfg_index, cfg_data   | one register write, no wait
//
// A set of codes passes through six restoring divisions before the first frame
// byte is offered; they run one quotient bit per cycle through one shared
// shift/subtract unit, five single-state steps sit among and after them, and
// the 26-byte CRC is folded in one bit per cycle. When the battery reading is
// at or past a limit its ratio division is skipped.
// The 29 frame bytes then leave one per accepted output beat.
// Reset clears control, the sequence number and the registers to defaults.
// The offered beat holds while out_ready is low; no new input
// beat is taken until the last frame byte has been delivered.
module sensor_telemetry_packet_framer_unit #(
	parameter int ADC_BITS = stpf_pkg::ADC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  stpf_pkg::sensor_in_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output stpf_pkg::frame_out_t   out_data,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data
);

	localparam logic [15:0] FS = 16'((32'd1 << ADC_BITS) - 32'd1);
	localparam logic [47:0] Q16 = 48'd65536;

	stpf_pkg::stpf_state_t state_q, state_d;

	// Configuration registers.
	logic [8:0]  weight_gas_q, weight_dust_q;
	logic [6:0]  priority_level_q, elevated_level_q;
	logic [31:0] node_ident_q;
	logic [7:0]  hazard_kind_q;
	logic [12:0] batt_full_q, batt_empty_q;

	// Captured codes, results and frame state.
	logic [11:0] dust_code_q, batt_code_q;
	logic [31:0] aqi_q, dust_q, mv_q, a1_q, a2_q;
	logic [40:0] comb_q;
	logic [7:0]  batt_pct_q;
	logic [15:0] seq_q, crc_q;
	logic [4:0]  pos_q;
	logic [2:0]  bit_q;
	logic [7:0]  frame_q [stpf_pkg::FRAME_LEN];
	logic [31:0] aqi_f_q, dust_f_q;
	logic [1:0]  urg_q;
	logic        prio_q;

	// Shared restoring divider: 48-bit dividend, 32-bit divisor.
	logic [47:0] num_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_sh;
	logic        fit;

	assign rem_sh = {rem_q[31:0], num_q[47]};
	assign fit    = rem_sh >= {1'b0, den_q};
	logic div_done;
	assign div_done = (cnt_q == 6'd47);

	// Float conversion, percent and saturation helpers (narrow, per value).
	function automatic logic [31:0] to_single(input logic [31:0] q);
		logic [4:0]  p;
		logic [31:0] mant;
		logic [31:0] rem;
		logic [31:0] half;
		logic [4:0]  s;
		logic [7:0]  ex;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (q[i]) begin
				p = 5'(i);
			end
		end
		if (q == 32'd0) begin
			return 32'd0;
		end
		if (p <= 5'd23) begin
			mant = q << (5'd23 - p);
		end else begin
			s    = p - 5'd23;
			rem  = q & ((32'd1 << s) - 32'd1);
			half = 32'd1 << (s - 5'd1);
			mant = q >> s;
			if (rem > half || (rem == half && mant[0])) begin
				mant = mant + 32'd1;
			end
			if (mant == 32'h0100_0000) begin
				mant = mant >> 1;
				p = p + 5'd1;
			end
		end
		ex = 8'(p) + 8'd111;
		return {1'b0, ex, mant[22:0]};
	endfunction

	function automatic logic [7:0] pct(input logic [40:0] q);
		logic [47:0] p;
		p = ({7'd0, q} * 48'd100) >> 16;
		return (p > 48'd255) ? 8'd255 : p[7:0];
	endfunction

	function automatic logic [11:0] sat(input logic [11:0] c);
		return ({4'd0, c} > FS) ? FS[11:0] : c;
	endfunction

	logic [31:0] off_a, off_d;
	assign off_a = 32'd50 * 32'd65536;
	assign off_d = 32'd25 * 32'd65536;
	logic [31:0] full_q16, empty_q16;
	assign full_q16  = {3'd0, batt_full_q, 16'd0};
	assign empty_q16 = {3'd0, batt_empty_q, 16'd0};

	// A battery reading at or past a limit needs no ratio.
	logic batt_limit;
	assign batt_limit = (mv_q >= full_q16) || (mv_q <= empty_q16);

	logic        prio_c, elev_c, rapid_c;
	assign prio_c  = ({7'd0, comb_q} * 48'd100) >= {25'd0, priority_level_q, 16'd0};
	assign elev_c  = ({7'd0, comb_q} * 48'd100) >= {25'd0, elevated_level_q, 16'd0};
	assign rapid_c = ({7'd0, comb_q} * 48'd10) > 48'd393216;

	logic crc_fb;
	assign crc_fb = crc_q[15] ^ frame_q[pos_q][3'd7 - bit_q];

	// Next state.
	always_comb begin
		state_d   = state_q;
		unique case (state_q)
			stpf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d   = stpf_pkg::ST_DIV_AQI;
				end
			end
			stpf_pkg::ST_DIV_AQI: if (div_done) state_d = stpf_pkg::ST_DIV_DUST;
			stpf_pkg::ST_DIV_DUST: if (div_done) state_d = stpf_pkg::ST_DIV_MV;
			stpf_pkg::ST_DIV_MV: if (div_done) state_d = stpf_pkg::ST_ANOM;
			stpf_pkg::ST_ANOM: state_d = stpf_pkg::ST_DIV_A1;
			stpf_pkg::ST_DIV_A1: if (div_done) state_d = stpf_pkg::ST_DIV_A2;
			stpf_pkg::ST_DIV_A2: if (div_done) state_d = stpf_pkg::ST_COMB;
			stpf_pkg::ST_COMB: state_d = stpf_pkg::ST_BATT;
			stpf_pkg::ST_BATT: begin
				state_d = batt_limit ? stpf_pkg::ST_FLOAT : stpf_pkg::ST_DIV_BATT;
			end
			stpf_pkg::ST_DIV_BATT: if (div_done) state_d = stpf_pkg::ST_FLOAT;
			stpf_pkg::ST_FLOAT: state_d = stpf_pkg::ST_BUILD;
			stpf_pkg::ST_BUILD: state_d = stpf_pkg::ST_CRC;
			stpf_pkg::ST_CRC: begin
				if (bit_q == 3'd7 && pos_q == 5'(stpf_pkg::CRC_LEN - 1)) begin
					state_d = stpf_pkg::ST_SEND;
				end
			end
			stpf_pkg::ST_SEND: begin
				if (out_ready && pos_q == 5'(stpf_pkg::FRAME_LEN - 1)) begin
					state_d = stpf_pkg::ST_IDLE;
				end
			end
			default: state_d = stpf_pkg::ST_IDLE;
		endcase
	end

	assign in_ready  = (state_q == stpf_pkg::ST_IDLE);
	assign out_valid = (state_q == stpf_pkg::ST_SEND);
	assign out_data.frame_byte = frame_q[pos_q];
	assign out_data.frame_last = (pos_q == 5'(stpf_pkg::FRAME_LEN - 1));
	assign out_data.urgency    = urg_q;

	// State register and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= stpf_pkg::ST_IDLE;
			weight_gas_q     <= 9'd141;
			weight_dust_q    <= 9'd115;
			priority_level_q <= 7'd70;
			elevated_level_q <= 7'd40;
			node_ident_q     <= 32'd877416272;
			hazard_kind_q    <= 8'd4;
			batt_full_q      <= 13'd4200;
			batt_empty_q     <= 13'd3300;
			seq_q            <= 16'd0;
			pos_q            <= 5'd0;
			bit_q            <= 3'd0;
			cnt_q            <= 6'd0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					stpf_pkg::REG_WEIGHT_GAS:  weight_gas_q     <= cfg_data[8:0];
					stpf_pkg::REG_WEIGHT_DUST: weight_dust_q    <= cfg_data[8:0];
					stpf_pkg::REG_PRIORITY:    priority_level_q <= cfg_data[6:0];
					stpf_pkg::REG_ELEVATED:    elevated_level_q <= cfg_data[6:0];
					stpf_pkg::REG_NODE_IDENT:  node_ident_q     <= cfg_data;
					stpf_pkg::REG_HAZARD_KIND: hazard_kind_q    <= cfg_data[7:0];
					stpf_pkg::REG_BATT_FULL:   batt_full_q      <= cfg_data[12:0];
					stpf_pkg::REG_BATT_EMPTY:  batt_empty_q     <= cfg_data[12:0];
					default: ;
				endcase
			end
			// Divider step counter restarts at each division state entry.
			if (state_q != state_d) begin
				cnt_q <= 6'd0;
			end else begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (state_q == stpf_pkg::ST_BUILD) begin
				seq_q <= seq_q + 16'd1;
				pos_q <= 5'd0;
				bit_q <= 3'd0;
			end else if (state_q == stpf_pkg::ST_CRC) begin
				bit_q <= bit_q + 3'd1;
				if (bit_q == 3'd7) begin
					pos_q <= (pos_q == 5'(stpf_pkg::CRC_LEN - 1)) ? 5'd0 : pos_q + 5'd1;
				end
			end else if (state_q == stpf_pkg::ST_SEND && out_ready) begin
				pos_q <= (pos_q == 5'(stpf_pkg::FRAME_LEN - 1)) ? 5'd0 : pos_q + 5'd1;
			end
		end
	end

	// Datapath: divider loading, one quotient bit per cycle, and results.
	always_ff @(posedge clk) begin
		// Load the divider on entry to each division state.
		if (state_q != state_d) begin
			unique case (state_d)
				stpf_pkg::ST_DIV_AQI: begin
					num_q <= 48'(sat(in_data.gas_code)) * 48'd500 * Q16;
					den_q <= {16'd0, FS};
				end
				stpf_pkg::ST_DIV_DUST: begin
					num_q <= 48'(sat(dust_code_q)) * 48'd660 * Q16;
					den_q <= {16'd0, FS};
				end
				stpf_pkg::ST_DIV_MV: begin
					num_q <= 48'(sat(batt_code_q)) * 48'd6600 * Q16;
					den_q <= {16'd0, FS};
				end
				stpf_pkg::ST_DIV_A1: begin
					num_q <= (aqi_q > off_a) ? {16'd0, aqi_q - off_a} : 48'd0;
					den_q <= 32'd250;
				end
				stpf_pkg::ST_DIV_A2: begin
					num_q <= (dust_q > off_d) ? {16'd0, dust_q - off_d} : 48'd0;
					den_q <= 32'd150;
				end
				stpf_pkg::ST_DIV_BATT: begin
					num_q <= 48'(mv_q - empty_q16) * 48'd100;
					den_q <= full_q16 - empty_q16;
				end
				default: ;
			endcase
			rem_q <= '0;
		end else begin
			num_q <= {num_q[46:0], fit};
			rem_q <= fit ? (rem_sh - {1'b0, den_q}) : rem_sh;
		end
		if (state_q == stpf_pkg::ST_IDLE && in_valid) begin
			dust_code_q <= in_data.dust_code;
			batt_code_q <= in_data.battery_code;
		end
		if (div_done) begin
			unique case (state_q)
				stpf_pkg::ST_DIV_AQI: aqi_q <= {num_q[30:0], fit};
				stpf_pkg::ST_DIV_DUST: begin
					dust_q <= ({num_q[30:0], fit} > 32'd180 * 32'd65536)
						? {num_q[30:0], fit} - 32'd180 * 32'd65536 : 32'd0;
				end
				stpf_pkg::ST_DIV_MV: mv_q <= {num_q[30:0], fit};
				stpf_pkg::ST_DIV_A1: begin
					a1_q <= ({num_q[30:0], fit} > 32'd65536) ? 32'd65536 : {num_q[30:0], fit};
				end
				stpf_pkg::ST_DIV_A2: begin
					a2_q <= ({num_q[30:0], fit} > 32'd65536) ? 32'd65536 : {num_q[30:0], fit};
				end
				stpf_pkg::ST_DIV_BATT: batt_pct_q <= {num_q[6:0], fit};
				default: ;
			endcase
		end
		if (state_q == stpf_pkg::ST_COMB) begin
			comb_q <= 41'(({32'd0, weight_gas_q} * {24'd0, a1_q[16:0]}
				+ {32'd0, weight_dust_q} * {24'd0, a2_q[16:0]}) >> 8);
		end
		// Battery limits decide ahead of the ratio.
		if (state_q == stpf_pkg::ST_BATT) begin
			if (mv_q >= full_q16) begin
				batt_pct_q <= 8'd100;
			end else if (mv_q <= empty_q16) begin
				batt_pct_q <= 8'd0;
			end
		end
		if (state_q == stpf_pkg::ST_FLOAT) begin
			aqi_f_q  <= to_single(aqi_q);
			dust_f_q <= to_single(dust_q);
			prio_q   <= prio_c;
			urg_q    <= prio_c ? 2'd2 : (elev_c ? 2'd1 : 2'd0);
		end
		// Fill the frame store.
		if (state_q == stpf_pkg::ST_BUILD) begin
			frame_q[0]  <= prio_q ? stpf_pkg::HDR_PRIORITY : stpf_pkg::HDR_NORMAL;
			frame_q[1]  <= node_ident_q[7:0];
			frame_q[2]  <= node_ident_q[15:8];
			frame_q[3]  <= node_ident_q[23:16];
			frame_q[4]  <= node_ident_q[31:24];
			frame_q[5]  <= hazard_kind_q;
			frame_q[6]  <= aqi_f_q[7:0];
			frame_q[7]  <= aqi_f_q[15:8];
			frame_q[8]  <= aqi_f_q[23:16];
			frame_q[9]  <= aqi_f_q[31:24];
			frame_q[10] <= pct({24'd0, a1_q[16:0]});
			frame_q[11] <= dust_f_q[7:0];
			frame_q[12] <= dust_f_q[15:8];
			frame_q[13] <= dust_f_q[23:16];
			frame_q[14] <= dust_f_q[31:24];
			frame_q[15] <= pct({24'd0, a2_q[16:0]});
			for (int i = 16; i < 21; i++) begin
				frame_q[i] <= 8'd0;
			end
			frame_q[21] <= pct(comb_q);
			frame_q[22] <= rapid_c ? 8'd3 : 8'd0;
			frame_q[23] <= batt_pct_q;
			frame_q[24] <= 8'(seq_q + 16'd1);
			frame_q[25] <= 8'((seq_q + 16'd1) >> 8);
			frame_q[28] <= stpf_pkg::END_MARK;
			crc_q <= stpf_pkg::CRC_INIT;
		end
		// Bit-serial CRC over the first 26 bytes.
		if (state_q == stpf_pkg::ST_CRC) begin
			crc_q <= {crc_q[14:0], 1'b0} ^ (crc_fb ? stpf_pkg::CRC_POLY : 16'd0);
			if (bit_q == 3'd7 && pos_q == 5'(stpf_pkg::CRC_LEN - 1)) begin
				frame_q[26] <= 8'({crc_q[14:0], 1'b0}
					^ (crc_fb ? stpf_pkg::CRC_POLY : 16'd0));
				frame_q[27] <= 8'(({crc_q[14:0], 1'b0}
					^ (crc_fb ? stpf_pkg::CRC_POLY : 16'd0)) >> 8);
			end
		end
	end

endmodule
